// ===== src/dscdf_pkg.sv =====
// Package for the dithered sample clock and DAC feed unit.
// Holds constants, register index codes and the result record.
// No dependencies.
`default_nettype none

package dscdf_pkg;

  localparam int unsigned BlockLenDefault      = 64;
  localparam int unsigned NominalPeriodDefault = 1999;

  localparam int unsigned ScaleW   = 21;
  localparam int unsigned VolumeW  = 16;
  localparam int unsigned BrightW  = 16;
  localparam int unsigned CfgDataW = 21;
  localparam int unsigned CfgAddrW = 2;

  localparam logic [31:0] LcgMul = 32'd1103515245;
  localparam logic [31:0] LcgAdd = 32'd12345;

  localparam logic [ScaleW-1:0]  ScaleReset  = 21'd65536;
  localparam logic [VolumeW-1:0] VolumeReset = 16'sd32767;
  localparam logic [7:0]         LevelReset  = 8'd0;

  typedef enum logic [CfgAddrW-1:0] {
    REG_PERIOD_SCALE   = 2'd0,
    REG_OUTPUT_VOLUME  = 2'd1,
    REG_LED_BRIGHTNESS = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [16:0] dac_word;
    logic [15:0] timer_match;
    logic [6:0]  buffer_index;
    logic        block_request;
    logic        refill_upper;
    logic        led_pwm_on;
    logic [31:0] tick_count;
  } result_t;

endpackage

`default_nettype wire

// ===== src/dithered_sample_clock_dac_feed_unit.sv =====
// Each result is registered into a two-entry output stage (register plus skid).
// Throughput: one item per cycle while the skid is empty; input stays ready
// while one result waits and stalls once both entries hold results.
// Reset: counter clears, LCG loads LcgAdd, period scale 1.0, volume full,
// LED level 0, output stage empty.
`default_nettype none

module dithered_sample_clock_dac_feed_unit
  import dscdf_pkg::*;
#(
  parameter int unsigned BLOCK_LEN      = BlockLenDefault,
  parameter int unsigned NOMINAL_PERIOD = NominalPeriodDefault
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CfgAddrW-1:0]  cfg_addr_i,
  input  wire logic [CfgDataW-1:0]  cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic signed [15:0]   sample_in_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [16:0]               dac_word_o,
  output logic [15:0]               timer_match_o,
  output logic [6:0]                buffer_index_o,
  output logic                      block_request_o,
  output logic                      refill_upper_o,
  output logic                      led_pwm_on_o,
  output logic [31:0]               tick_count_o
);

  localparam int unsigned ModW   = $clog2(2 * BLOCK_LEN);
  localparam int unsigned NpW    = $clog2(NOMINAL_PERIOD + 1);
  localparam int unsigned ProdW  = ScaleW + NpW;
  localparam logic [ModW-1:0] ModLast = ModW'(2 * BLOCK_LEN - 1);
  localparam logic [ModW-1:0] ModHalf = ModW'(BLOCK_LEN);
  localparam logic [63:0] BaseReset64 =
    64'(NOMINAL_PERIOD) * 64'(ScaleReset);

  logic [31:0]         base_q, base_d;
  logic signed [15:0]  volume_q, volume_d;
  logic [7:0]          level_q, level_d;
  logic [31:0]         cnt_q, cnt_d;
  logic [ModW-1:0]     mod_q, mod_d;
  logic [31:0]         lcg_q, lcg_d;

  logic [ProdW-1:0]    scale_prod;
  logic [63:0]         scale_prod_ext;
  logic [31:0]         bright_sq;

  logic                in_xfer, out_xfer;
  logic signed [31:0]  vol_prod, vol_bias;
  logic [31:0]         tp;
  logic [31:0]         mod_ext;
  result_t             res;

  result_t             out_q, skid_q;
  logic                out_valid_q, skid_valid_q;

  assign scale_prod     = ProdW'(cfg_data_i) * ProdW'(NOMINAL_PERIOD);
  assign scale_prod_ext = 64'(scale_prod);
  assign bright_sq      = 32'(cfg_data_i[BrightW-1:0]) * 32'(cfg_data_i[BrightW-1:0]);

  always_comb begin
    base_d   = base_q;
    volume_d = volume_q;
    level_d  = level_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        REG_PERIOD_SCALE: begin
          if (scale_prod_ext <= 64'hFFFF_FFFF) begin
            base_d = scale_prod_ext[31:0];
          end
        end
        REG_OUTPUT_VOLUME:  volume_d = cfg_data_i[VolumeW-1:0];
        REG_LED_BRIGHTNESS: level_d  = bright_sq[31:24];
        default: ;
      endcase
    end
  end

  assign in_ready_o = !skid_valid_q;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_xfer   = out_valid_q && out_ready_i;

  always_comb begin
    cnt_d = cnt_q + 32'd1;
    lcg_d = lcg_q * LcgMul + LcgAdd;
    if (cnt_q == 32'hFFFF_FFFF || mod_q == ModLast) begin
      mod_d = '0;
    end else begin
      mod_d = mod_q + ModW'(1);
    end
  end

  assign vol_prod = volume_q * sample_in_i;
  assign vol_bias = vol_prod + (vol_prod[31] ? 32'sd32767 : 32'sd0);
  assign tp       = base_q + {15'd0, lcg_q[31:15]};
  assign mod_ext  = 32'(mod_d);

  always_comb begin
    res.dac_word      = {1'b1, ~vol_bias[30], vol_bias[29:21], 6'd0};
    res.timer_match   = tp[31:16];
    res.buffer_index  = mod_ext[6:0];
    res.block_request = (mod_d == '0) || (mod_d == ModHalf);
    res.refill_upper  = (mod_d == '0);
    res.led_pwm_on    = cnt_d[7:0] > level_q;
    res.tick_count    = cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= BaseReset64[31:0];
      volume_q <= VolumeReset;
      level_q  <= LevelReset;
      cnt_q    <= '0;
      mod_q    <= '0;
      lcg_q    <= LcgAdd;
    end else begin
      base_q   <= base_d;
      volume_q <= volume_d;
      level_q  <= level_d;
      if (in_xfer) begin
        cnt_q <= cnt_d;
        mod_q <= mod_d;
        lcg_q <= lcg_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (out_xfer) begin
        if (skid_valid_q) begin
          skid_valid_q <= in_xfer;
        end else begin
          out_valid_q <= in_xfer;
        end
      end else if (in_xfer) begin
        if (out_valid_q) begin
          skid_valid_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_xfer) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
        if (in_xfer) begin
          skid_q <= res;
        end
      end else if (in_xfer) begin
        out_q <= res;
      end
    end else if (in_xfer) begin
      if (out_valid_q) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign dac_word_o      = out_q.dac_word;
  assign timer_match_o   = out_q.timer_match;
  assign buffer_index_o  = out_q.buffer_index;
  assign block_request_o = out_q.block_request;
  assign refill_upper_o  = out_q.refill_upper;
  assign led_pwm_on_o    = out_q.led_pwm_on;
  assign tick_count_o    = out_q.tick_count;

endmodule

`default_nettype wire

// ===== src/dscdf_checker.sv =====
// Port-level checker for the dithered sample clock and DAC feed unit.
// Bound to the top level below; sees its ports only.
`default_nettype none

module dscdf_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [16:0] dac_word_o,
  input wire logic [31:0] tick_count_o,
  input wire logic        block_request_o,
  input wire logic        refill_upper_o
);

  logic [31:0] last_cnt_q;
  logic        seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q     <= 1'b0;
      last_cnt_q <= '0;
    end else if (out_valid_o && out_ready_i) begin
      seen_q     <= 1'b1;
      last_cnt_q <= tick_count_o;
    end
  end

  a_count_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && seen_q |-> tick_count_o == last_cnt_q + 32'd1)
    else $error("tick count did not advance by one between transfers");

  a_refill_needs_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && refill_upper_o |-> block_request_o)
    else $error("refill flag without block request");

  a_dac_format: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> dac_word_o[16] && dac_word_o[5:0] == 6'd0)
    else $error("DAC word format broken");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(tick_count_o))
    else $error("stalled result dropped or changed");

endmodule

bind dithered_sample_clock_dac_feed_unit dscdf_checker u_dscdf_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .dac_word_o      (dac_word_o),
  .tick_count_o    (tick_count_o),
  .block_request_o (block_request_o),
  .refill_upper_o  (refill_upper_o)
);

`default_nettype wire

// ===== tb/dithered_sample_clock_dac_feed_unit_test.sv =====
// Self-checking testbench for dithered_sample_clock_dac_feed_unit.
// Drives samples and register writes and checks each result against a predictor.
// Depends on dscdf_pkg and the unit itself.
module dithered_sample_clock_dac_feed_unit_test;
  import dscdf_pkg::*;

  localparam int unsigned BlockLen      = BlockLenDefault;
  localparam int unsigned NominalPeriod = NominalPeriodDefault;
  localparam int unsigned CycleLimit    = 200000;
  localparam int unsigned PhaseItems    = 100;
  localparam int unsigned Phases        = 6;
  localparam logic [CfgAddrW-1:0] RegUnused = 2'd3;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [CfgAddrW-1:0]   addr;
    logic [CfgDataW-1:0]   data;
    logic signed [15:0]    sample;
    logic                  dac_fixed;
    logic [16:0]           dac;
  } stim_row_t;

  localparam int unsigned DirectedLen = 21;
  localparam stim_row_t DirectedRows [DirectedLen] = '{
    '{ROW_SAMPLE, REG_PERIOD_SCALE,   21'h000000, 16'h0000, 1'b1, 17'h18000},
    '{ROW_SAMPLE, REG_PERIOD_SCALE,   21'h000000, 16'h7FFF, 1'b1, 17'h1FFC0},
    '{ROW_SAMPLE, REG_PERIOD_SCALE,   21'h000000, 16'h8000, 1'b1, 17'h10000},
    '{ROW_SAMPLE, REG_PERIOD_SCALE,   21'h000000, 16'hFFFF, 1'b1, 17'h18000},
    '{ROW_SAMPLE, REG_PERIOD_SCALE,   21'h000000, 16'h0001, 1'b1, 17'h18000},
    '{ROW_SAMPLE, REG_PERIOD_SCALE,   21'h000000, 16'h5555, 1'b0, 17'h00000},
    '{ROW_SAMPLE, REG_PERIOD_SCALE,   21'h000000, 16'hAAAA, 1'b0, 17'h00000},
    '{ROW_WRITE,  REG_OUTPUT_VOLUME,  21'h1F8000, 16'h0000, 1'b0, 17'h00000},
    '{ROW_SAMPLE, REG_PERIOD_SCALE,   21'h000000, 16'h8000, 1'b1, 17'h10000},
    '{ROW_SAMPLE, REG_PERIOD_SCALE,   21'h000000, 16'h7FFF, 1'b1, 17'h10000},
    '{ROW_SAMPLE, REG_PERIOD_SCALE,   21'h000000, 16'h0000, 1'b1, 17'h18000},
    '{ROW_WRITE,  REG_PERIOD_SCALE,   21'h000000, 16'h0000, 1'b0, 17'h00000},
    '{ROW_WRITE,  REG_LED_BRIGHTNESS, 21'h1FFFFF, 16'h0000, 1'b0, 17'h00000},
    '{ROW_WRITE,  RegUnused,          21'h0ABCDE, 16'h0000, 1'b0, 17'h00000},
    '{ROW_SAMPLE, REG_PERIOD_SCALE,   21'h000000, 16'h3039, 1'b0, 17'h00000},
    '{ROW_SAMPLE, REG_PERIOD_SCALE,   21'h000000, 16'hCFC7, 1'b0, 17'h00000},
    '{ROW_WRITE,  REG_PERIOD_SCALE,   21'h1FFFFF, 16'h0000, 1'b0, 17'h00000},
    '{ROW_WRITE,  REG_LED_BRIGHTNESS, 21'h001000, 16'h0000, 1'b0, 17'h00000},
    '{ROW_WRITE,  REG_OUTPUT_VOLUME,  21'h004000, 16'h0000, 1'b0, 17'h00000},
    '{ROW_SAMPLE, REG_PERIOD_SCALE,   21'h000000, 16'h7FFF, 1'b0, 17'h00000},
    '{ROW_SAMPLE, REG_PERIOD_SCALE,   21'h000000, 16'h8000, 1'b1, 17'h14000}
  };

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgAddrW-1:0] cfg_addr_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic signed [15:0]  sample_in_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [16:0]         dac_word_o;
  logic [15:0]         timer_match_o;
  logic [6:0]          buffer_index_o;
  logic                block_request_o;
  logic                refill_upper_o;
  logic                led_pwm_on_o;
  logic [31:0]         tick_count_o;

  logic                dac_fixed_on;
  logic [16:0]         dac_fixed;
  int unsigned         send_odds = 6;
  int unsigned         read_odds = 6;
  int unsigned         failures = 0;
  int unsigned         cycles = 0;

  logic [31:0]         tick_ctr = '0;
  logic [31:0]         dither_state = '0;
  logic [ScaleW-1:0]   scale_reg = ScaleReset;
  logic signed [15:0]  volume_reg = VolumeReset;
  logic [15:0]         bright_reg = '0;
  result_t             expected_feeds [$];

  dithered_sample_clock_dac_feed_unit #(
    .BLOCK_LEN      (BlockLen),
    .NOMINAL_PERIOD (NominalPeriod)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .sample_in_i     (sample_in_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .dac_word_o      (dac_word_o),
    .timer_match_o   (timer_match_o),
    .buffer_index_o  (buffer_index_o),
    .block_request_o (block_request_o),
    .refill_upper_o  (refill_upper_o),
    .led_pwm_on_o    (led_pwm_on_o),
    .tick_count_o    (tick_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic void apply_write(logic [CfgAddrW-1:0] addr, logic [CfgDataW-1:0] data);
    logic [63:0] span;
    span = {43'd0, data} * 64'(NominalPeriod);
    case (addr)
      REG_PERIOD_SCALE: begin
        if (span <= 64'hFFFF_FFFF) scale_reg = data;
      end
      REG_OUTPUT_VOLUME:  volume_reg = data[15:0];
      REG_LED_BRIGHTNESS: bright_reg = data[15:0];
      default: ;
    endcase
  endfunction

  function automatic result_t next_feed(logic signed [15:0] smp);
    result_t     r;
    logic [31:0] period;
    logic [31:0] square;
    logic [31:0] level_src;
    int          scaled;
    logic [31:0] biased;
    logic        req;
    tick_ctr     = tick_ctr + 32'd1;
    dither_state = dither_state * LcgMul + LcgAdd;
    period = 32'(NominalPeriod) * {11'd0, scale_reg} + (dither_state >> 15);
    scaled = (int'(volume_reg) * int'(smp)) / 32768;
    biased = 32'(scaled) + 32'h8000;
    req    = (tick_ctr % 32'(BlockLen)) == 32'd0;
    square = {16'd0, bright_reg} * {16'd0, bright_reg};
    level_src = square >> 24;
    r.dac_word      = {1'b1, biased[15:6], 6'd0};
    r.timer_match   = period[31:16];
    r.buffer_index  = 7'(tick_ctr % (32'(BlockLen) * 32'd2));
    r.block_request = req;
    r.refill_upper  = req && (((tick_ctr / 32'(BlockLen)) & 32'd1) == 32'd0);
    r.led_pwm_on    = tick_ctr[7:0] > level_src[7:0];
    r.tick_count    = tick_ctr;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] seen);
    if (want !== seen) begin
      $error("%s: expected %0h, got %0h", name, want, seen);
      failures++;
    end
  endfunction

  always @(posedge clk_i) begin : scoreboard
    result_t want;
    if (rst_ni) begin
      if (cfg_we_i) apply_write(cfg_addr_i, cfg_data_i);
      if (in_valid_i && in_ready_o) begin
        want = next_feed(sample_in_i);
        if (dac_fixed_on) want.dac_word = dac_fixed;
        expected_feeds.push_back(want);
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_feeds.size() == 0) begin
          $error("result transfer with no expectation pending");
          failures++;
        end else begin
          want = expected_feeds.pop_front();
          check_field("dac_word", 32'(want.dac_word), 32'(dac_word_o));
          check_field("timer_match", 32'(want.timer_match), 32'(timer_match_o));
          check_field("buffer_index", 32'(want.buffer_index), 32'(buffer_index_o));
          check_field("block_request", 32'(want.block_request), 32'(block_request_o));
          check_field("refill_upper", 32'(want.refill_upper), 32'(refill_upper_o));
          check_field("led_pwm_on", 32'(want.led_pwm_on), 32'(led_pwm_on_o));
          check_field("tick_count", want.tick_count, tick_count_o);
        end
      end
    end
  end

  initial begin : reader
    int n;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (read_odds != 0 && $urandom_range(1, read_odds) == 1) begin
        out_ready_i <= 1'b0;
        n = $urandom_range(1, 19);
        repeat (n - 1) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic send_sample(logic signed [15:0] smp, logic fixed_on, logic [16:0] fixed);
    int n;
    if (send_odds != 0 && $urandom_range(1, send_odds) == 1) begin
      n = $urandom_range(1, 19);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    sample_in_i  <= smp;
    dac_fixed_on <= fixed_on;
    dac_fixed    <= fixed;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // hold off until the result of every transfer in flight has been taken
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_feeds.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgAddrW-1:0] addr, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= addr;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  function automatic logic signed [15:0] random_sample();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return $urandom_range(0, 1) ? 16'h0000 : 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    stim_row_t row;
    cfg_we_i     = 1'b0;
    cfg_addr_i   = '0;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    sample_in_i  = '0;
    dac_fixed_on = 1'b0;
    dac_fixed    = '0;
    rst_ni       = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < DirectedLen; i++) begin
      row = DirectedRows[i];
      if (row.kind == ROW_WRITE) begin
        wait_drained();
        write_reg(row.addr, row.data);
      end else begin
        send_sample(row.sample, row.dac_fixed, row.dac);
      end
    end

    for (int p = 0; p < Phases; p++) begin
      wait_drained();
      case (p)
        0: begin
          write_reg(REG_PERIOD_SCALE, 21'h000000);
          write_reg(REG_OUTPUT_VOLUME, 21'h158000);
          write_reg(REG_LED_BRIGHTNESS, 21'h00FFFF);
        end
        1: begin
          write_reg(REG_PERIOD_SCALE, 21'h1FFFFF);
          write_reg(REG_OUTPUT_VOLUME, 21'h007FFF);
          write_reg(REG_LED_BRIGHTNESS, 21'h000000);
        end
        default: begin
          write_reg(REG_PERIOD_SCALE, $urandom_range(0, 1) ?
                    21'($urandom_range(32768, 131072)) : 21'($urandom_range(0, 2097151)));
          write_reg(REG_OUTPUT_VOLUME, 21'($urandom));
          write_reg(REG_LED_BRIGHTNESS, 21'($urandom));
          write_reg(RegUnused, 21'($urandom));
        end
      endcase
      send_odds = (p == Phases - 1) ? 0 : $urandom_range(3, 12);
      read_odds = (p == Phases - 1) ? 0 : $urandom_range(3, 12);
      repeat (PhaseItems) send_sample(random_sample(), 1'b0, '0);
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
